>>> hw/rtl/reed_solomon_parity_encoder_unit_assert.svh
// assertion macros for the reed-solomon parity encoder unit
// no dependencies; included by the top level only
`ifndef REED_SOLOMON_PARITY_ENCODER_UNIT_ASSERT_SVH
`define REED_SOLOMON_PARITY_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RSPE_ASSERT_NOW(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define RSPE_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> hw/rtl/rspe_pkg.sv
// shared constants and gf(256) arithmetic for the parity encoder
// no dependencies
`default_nettype none

package rspe_pkg;

	localparam int          BYTE_W       = 8;
	localparam int          CFG_W        = 6;
	localparam int          RESET_PARITY = 10;
	// low byte of the field polynomial x^8+x^4+x^3+x^2+1
	localparam logic [7:0]  FIELD_LOW    = 8'h1D;

	// multiply by alpha (x) in gf(256)
	function automatic logic [7:0] gf_xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? FIELD_LOW : 8'h00);
	endfunction

	// general gf(256) multiply, shift-and-add over the eight bits of b
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] sh;
		acc = 8'h00;
		sh  = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) acc = acc ^ sh;
			sh = gf_xtime(sh);
		end
		return acc;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rspe_data_if.sv
// input channel: one message byte per word with an end-of-block flag
// no dependencies
`default_nettype none

interface rspe_data_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       block_end;

	modport source (output valid, output data_byte, output block_end, input ready);
	modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rspe_parity_if.sv
// output channel: one parity byte per word with a last flag
// no dependencies
`default_nettype none

interface rspe_parity_if;
	logic       valid;
	logic       ready;
	logic [7:0] parity_byte;
	logic       parity_last;

	modport source (output valid, output parity_byte, output parity_last, input ready);
	modport sink   (input valid, input parity_byte, input parity_last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rspe_gen_build.sv
// generator polynomial builder: multiplies in one (x + alpha^i) per cycle
// depends on rspe_pkg
`default_nettype none

module rspe_gen_build
	import rspe_pkg::*;
#(
	parameter int MAX_PARITY = 32,
	parameter int CW         = 6
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [CW-1:0]                 count,
	output logic                               busy,
	output logic [MAX_PARITY-1:0][BYTE_W-1:0]  coef
);

	// coef_q[j] holds g(n-1-j) once done, so cell j of the lfsr reads entry j
	logic [MAX_PARITY-1:0][BYTE_W-1:0] coef_q;
	logic [MAX_PARITY-1:0][BYTE_W-1:0] coef_nx;
	logic [BYTE_W-1:0]                 root_q;
	logic [CW-1:0]                     iter_q;
	logic [CW-1:0]                     iter_inc;
	logic                              busy_q;

	assign iter_inc = iter_q + CW'(1);

	// multiply the reversed polynomial by (x + root): a shift with a scaled tap
	always_comb begin
		coef_nx[0] = root_q ^ coef_q[0];
		for (int j = 1; j < MAX_PARITY; j++) begin
			coef_nx[j] = gf_mul(root_q, coef_q[j-1]) ^ coef_q[j];
		end
	end

	// build sequencer; reset starts a build for the count held at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			root_q <= 8'h01;
			iter_q <= '0;
			busy_q <= 1'b1;
		end else if (start) begin
			coef_q <= '0;
			root_q <= 8'h01;
			iter_q <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			coef_q <= coef_nx;
			root_q <= gf_xtime(root_q);
			iter_q <= iter_inc;
			if (iter_inc == count) busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign coef = coef_q;

endmodule

`default_nettype wire

>>> hw/rtl/rspe_lfsr_core.sv
// input register and remainder lfsr, one data byte per cycle unless a build or a full parity buffer holds it
// depends on rspe_pkg and rspe_data_if
`default_nettype none

module rspe_lfsr_core
	import rspe_pkg::*;
#(
	parameter int MAX_PARITY = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	rspe_data_if.sink                              data_in,
	input  wire logic                              gen_busy,
	input  wire logic                              clr,
	input  wire logic [MAX_PARITY-1:0][BYTE_W-1:0] coef,
	input  wire logic                              buf_free,
	output logic                                   load,
	output logic [MAX_PARITY-1:0][BYTE_W-1:0]      par,
	output logic                                   s1_valid
);

	logic                              valid_s1;
	logic [BYTE_W-1:0]                 data_s1;
	logic                              last_s1;
	logic [MAX_PARITY-1:0][BYTE_W-1:0] rem_q;
	logic [MAX_PARITY-1:0][BYTE_W-1:0] rem_nx;
	logic [BYTE_W-1:0]                 fb;
	logic                              advance;
	logic                              take;

	// a last word waits until the parity buffer can take the remainder
	assign advance       = valid_s1 && (!last_s1 || buf_free);
	assign data_in.ready = !gen_busy && (!valid_s1 || advance);
	assign take          = data_in.valid && data_in.ready;

	// remainder update; cells past the count stay zero, so no count is needed
	always_comb begin
		fb = data_s1 ^ rem_q[0];
		for (int j = 0; j < MAX_PARITY - 1; j++) begin
			rem_nx[j] = rem_q[j+1] ^ gf_mul(fb, coef[j]);
		end
		rem_nx[MAX_PARITY-1] = gf_mul(fb, coef[MAX_PARITY-1]);
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= data_in.data_byte;
			last_s1 <= data_in.block_end;
		end
	end

	// remainder register, cleared at block end and on a count write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (clr) begin
			rem_q <= '0;
		end else if (advance) begin
			rem_q <= last_s1 ? '0 : rem_nx;
		end
	end

	assign load     = advance && last_s1;
	assign par      = rem_nx;
	assign s1_valid = valid_s1;

endmodule

`default_nettype wire

>>> hw/rtl/rspe_parity_buf.sv
// parity output buffer: loads a whole remainder, shifts out one byte per word
// depends on rspe_pkg and rspe_parity_if
`default_nettype none

module rspe_parity_buf
	import rspe_pkg::*;
#(
	parameter int MAX_PARITY = 32,
	parameter int CW         = 6
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              load,
	input  wire logic [MAX_PARITY-1:0][BYTE_W-1:0] par,
	input  wire logic [CW-1:0]                     count,
	rspe_parity_if.source                          parity_out,
	output logic                                   buf_free
);

	logic [MAX_PARITY-1:0][BYTE_W-1:0] buf_q;
	logic [CW-1:0]                     cnt_q;
	logic                              take;

	assign take     = parity_out.valid && parity_out.ready;
	assign buf_free = (cnt_q == '0) || ((cnt_q == CW'(1)) && take);

	// bytes left to send
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= count;
		end else if (take) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// shift register, highest coefficient at the head
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= par;
		end else if (take) begin
			for (int j = 0; j < MAX_PARITY - 1; j++) begin
				buf_q[j] <= buf_q[j+1];
			end
			buf_q[MAX_PARITY-1] <= '0;
		end
	end

	assign parity_out.valid       = (cnt_q != '0);
	assign parity_out.parity_byte = buf_q[0];
	assign parity_out.parity_last = (cnt_q == CW'(1));

endmodule

`default_nettype wire

>>> hw/rtl/reed_solomon_parity_encoder_unit.sv
// top level of the gf(256) reed-solomon parity encoder (polynomial 0x11d)
// depends on rspe_pkg, rspe_data_if, rspe_parity_if, rspe_gen_build,
// rspe_lfsr_core, rspe_parity_buf and the assertion macro header
//
// usage:
//  data_in takes one message byte per word, highest order first; block_end
//  marks the last byte of a block. data bytes are not passed on.
//  parity_out gives count parity bytes after each block, highest coefficient
//  first, parity_last on the final one.
//  cfg_wr_en/cfg_wr_data set the parity count (0 reads as 1, values above
//  MAX_PARITY as MAX_PARITY); a write clears the remainder and rebuilds the
//  generator, one root per cycle, so data_in.ready stays low while the build runs.
//  reset does the same for a count of 10.
//  throughput: one data byte per cycle outside generator builds and block-end waits.
//  the first parity byte is valid once the last data byte has passed the input
//  register into the parity buffer; the rest follow one per cycle while ready is high.
//  a block end waits in the input register until the previous block's parity
//  has drained, so short blocks are paced by the parity output.
//  when parity_out stalls the buffer holds and data_in keeps accepting until
//  the next block end reaches the input register.
`default_nettype none
`include "reed_solomon_parity_encoder_unit_assert.svh"

module reed_solomon_parity_encoder_unit
	import rspe_pkg::*;
#(
	parameter int MAX_PARITY = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	rspe_data_if.sink             data_in,
	rspe_parity_if.source         parity_out
);

	localparam int CW      = $clog2(MAX_PARITY + 1);
	localparam int RESET_N = (RESET_PARITY > MAX_PARITY) ? MAX_PARITY : RESET_PARITY;

	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     count_wr;
	logic                              gen_busy;
	logic [MAX_PARITY-1:0][BYTE_W-1:0] coef;
	logic                              buf_free;
	logic                              par_load;
	logic [MAX_PARITY-1:0][BYTE_W-1:0] par;
	logic                              s1_valid;

	// clamp the written count into 1 .. MAX_PARITY
	always_comb begin
		if (cfg_wr_data == '0) begin
			count_wr = CW'(1);
		end else if (int'(cfg_wr_data) > MAX_PARITY) begin
			count_wr = CW'(MAX_PARITY);
		end else begin
			count_wr = CW'(cfg_wr_data);
		end
	end

	// parity count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(RESET_N);
		end else if (cfg_wr_en) begin
			count_q <= count_wr;
		end
	end

	rspe_gen_build #(
		.MAX_PARITY (MAX_PARITY),
		.CW         (CW)
	) u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_wr_en),
		.count  (count_q),
		.busy   (gen_busy),
		.coef   (coef)
	);

	rspe_lfsr_core #(
		.MAX_PARITY (MAX_PARITY)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.data_in  (data_in),
		.gen_busy (gen_busy),
		.clr      (cfg_wr_en),
		.coef     (coef),
		.buf_free (buf_free),
		.load     (par_load),
		.par      (par),
		.s1_valid (s1_valid)
	);

	rspe_parity_buf #(
		.MAX_PARITY (MAX_PARITY),
		.CW         (CW)
	) u_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (par_load),
		.par        (par),
		.count      (count_q),
		.parity_out (parity_out),
		.buf_free   (buf_free)
	);

	// checks across the builder, the lfsr and the output buffer
	`RSPE_ASSERT_NOW(a_load_needs_room, clk, arst_n, par_load, buf_free, "parity load over undrained buffer")
	`RSPE_ASSERT_NEXT(a_cfg_starts_build, clk, arst_n, cfg_wr_en, gen_busy, "count write did not start a generator build")
	`RSPE_ASSERT_NOW(a_build_input_empty, clk, arst_n, gen_busy, !s1_valid, "data word held during generator build")

endmodule

`default_nettype wire

>>> dv/tb.sv
// self-checking testbench for the gf(256) reed-solomon parity encoder unit
// depends on rspe_pkg, rspe_data_if, rspe_parity_if and reed_solomon_parity_encoder_unit
// a directed table, then random blocks, scored against an in-bench lfsr predictor or a pinned value
`timescale 1ns / 1ps

module tb;
	import rspe_pkg::*;

	localparam int MAX_PAR      = 32;
	localparam int DRAIN_GUARD  = 4;
	localparam int END_GUARD    = 8;
	localparam int STALL_LIMIT  = 2000;
	localparam int N_DIRECTED   = 25;
	localparam int N_PHASES     = 6;
	localparam int PHASE_WORDS  = 32;

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [5:0] cfg_val;
		logic [7:0] data;
		logic       last;
		logic       pinned;
		logic [7:0] pin_val;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] parity_byte;
		logic       parity_last;
	} parity_word_t;

	// directed rows; pinned rows carry a parity value that holds for every parity byte of the block
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{ROW_WORD, 6'd0,  8'h00, 1'b1, 1'b1, 8'h00},	// zero block right after reset
		'{ROW_WORD, 6'd0,  8'hFF, 1'b0, 1'b0, 8'h00},
		'{ROW_WORD, 6'd0,  8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WORD, 6'd0,  8'h80, 1'b1, 1'b0, 8'h00},
		'{ROW_WORD, 6'd0,  8'h01, 1'b1, 1'b0, 8'h00},
		'{ROW_CFG,  6'd0,  8'h00, 1'b0, 1'b0, 8'h00},	// zero count taken as one
		'{ROW_WORD, 6'd0,  8'hA5, 1'b0, 1'b0, 8'h00},
		'{ROW_WORD, 6'd0,  8'h5A, 1'b1, 1'b1, 8'hFF},	// one parity byte is the xor of the block
		'{ROW_WORD, 6'd0,  8'h80, 1'b1, 1'b1, 8'h80},
		'{ROW_CFG,  6'd63, 8'h00, 1'b0, 1'b0, 8'h00},	// oversized count clamps to max
		'{ROW_WORD, 6'd0,  8'hFF, 1'b0, 1'b0, 8'h00},
		'{ROW_WORD, 6'd0,  8'h01, 1'b1, 1'b0, 8'h00},
		'{ROW_WORD, 6'd0,  8'h00, 1'b1, 1'b1, 8'h00},
		'{ROW_CFG,  6'd33, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WORD, 6'd0,  8'h7E, 1'b1, 1'b0, 8'h00},
		'{ROW_CFG,  6'd32, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WORD, 6'd0,  8'h55, 1'b1, 1'b0, 8'h00},
		'{ROW_CFG,  6'd21, 8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WORD, 6'd0,  8'hC3, 1'b1, 1'b0, 8'h00},
		'{ROW_WORD, 6'd0,  8'h12, 1'b0, 1'b0, 8'h00},
		'{ROW_CFG,  6'd42, 8'h00, 1'b0, 1'b0, 8'h00},	// count write in the middle of a block
		'{ROW_WORD, 6'd0,  8'h34, 1'b1, 1'b0, 8'h00},
		'{ROW_CFG,  6'd2,  8'h00, 1'b0, 1'b0, 8'h00},
		'{ROW_WORD, 6'd0,  8'hFF, 1'b0, 1'b0, 8'h00},
		'{ROW_WORD, 6'd0,  8'hFF, 1'b1, 1'b0, 8'h00}
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [5:0] cfg_wr_data;

	rspe_data_if   data_ch ();
	rspe_parity_if parity_ch ();

	reed_solomon_parity_encoder_unit #(
		.MAX_PARITY(MAX_PAR)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.data_in    (data_ch),
		.parity_out (parity_ch)
	);

	// predictor state
	logic [7:0]   remainder [MAX_PAR];
	logic [7:0]   gen_low [MAX_PAR];
	int           parity_n;
	parity_word_t pending_parity [$];

	int errors;
	int idle_cycles;
	bit quiet;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// gf(256) product, reduced by 0x11d
	function automatic logic [7:0] gf256_mult(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] prod;
		logic [7:0] m;
		logic [7:0] r;
		prod = 8'h00;
		m    = a;
		r    = b;
		while (r != 8'h00) begin
			if (r[0]) prod = prod ^ m;
			m = {m[6:0], 1'b0} ^ (m[7] ? FIELD_LOW : 8'h00);
			r = r >> 1;
		end
		return prod;
	endfunction

	// clamp the count, rebuild the generator and clear the remainder
	function automatic void load_parity_count(input logic [5:0] v);
		logic [7:0] poly [MAX_PAR+1];
		logic [7:0] root;
		int n;
		n = (v == 6'd0) ? 1 : ((int'(v) > MAX_PAR) ? MAX_PAR : int'(v));
		foreach (poly[k]) poly[k] = 8'h00;
		poly[0] = 8'h01;
		root = 8'h01;
		for (int i = 0; i < n; i++) begin
			poly[i+1] = 8'h01;
			for (int j = i; j > 0; j--)
				poly[j] = gf256_mult(poly[j], root) ^ poly[j-1];
			poly[0] = gf256_mult(poly[0], root);
			root = gf256_mult(root, 8'h02);
		end
		for (int i = 0; i < MAX_PAR; i++) begin
			gen_low[i]   = (i < n) ? poly[i] : 8'h00;
			remainder[i] = 8'h00;
		end
		parity_n = n;
	endfunction

	// one lfsr step; a block end queues the parity words and clears the remainder
	function automatic void lfsr_feed(input logic [7:0] d, input logic last, input logic pinned,
			input logic [7:0] pin_val);
		logic [7:0] fb;
		parity_word_t w;
		fb = d ^ remainder[0];
		for (int j = 0; j + 1 < parity_n; j++)
			remainder[j] = remainder[j+1] ^ gf256_mult(fb, gen_low[parity_n-1-j]);
		remainder[parity_n-1] = gf256_mult(fb, gen_low[0]);
		if (last) begin
			for (int j = 0; j < parity_n; j++) begin
				w.parity_byte = pinned ? pin_val : remainder[j];
				w.parity_last = (j == parity_n - 1);
				pending_parity.push_back(w);
			end
			foreach (remainder[k]) remainder[k] = 8'h00;
		end
	endfunction

	// present one data word after a random gap and wait for it to be taken
	task automatic send_word(input logic [7:0] d, input logic last, input logic pinned,
			input logic [7:0] pin_val);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			data_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_ch.valid     <= 1'b1;
		data_ch.data_byte <= d;
		data_ch.block_end <= last;
		do @(posedge clk); while (!data_ch.ready);
		lfsr_feed(d, last, pinned, pin_val);
	endtask

	// hold the sender until every parity word is back and the pipe has settled
	task automatic drain_parity();
		data_ch.valid <= 1'b0;
		while (pending_parity.size() != 0) @(posedge clk);
		repeat (DRAIN_GUARD) @(posedge clk);
	endtask

	task automatic write_count(input logic [5:0] v);
		drain_parity();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		load_parity_count(v);
	endtask

	// parity sink with random stalls
	initial begin
		int stall;
		parity_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				parity_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			parity_ch.ready <= 1'b1;
			do @(posedge clk); while (!parity_ch.valid);
		end
	end

	// score each accepted parity word against the oldest expectation
	always @(posedge clk) begin
		parity_word_t exp_w;
		if (arst_n && parity_ch.valid && parity_ch.ready) begin
			if (pending_parity.size() == 0) begin
				$error("unexpected parity word: parity_byte %h parity_last %b",
					parity_ch.parity_byte, parity_ch.parity_last);
				errors++;
			end else begin
				exp_w = pending_parity.pop_front();
				if (parity_ch.parity_byte !== exp_w.parity_byte) begin
					$error("parity_byte: expected %h, got %h", exp_w.parity_byte,
						parity_ch.parity_byte);
					errors++;
				end
				if (parity_ch.parity_last !== exp_w.parity_last) begin
					$error("parity_last: expected %b, got %b", exp_w.parity_last,
						parity_ch.parity_last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (data_ch.valid && data_ch.ready) ||
				(parity_ch.valid && parity_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("** reed_solomon_parity_encoder_unit: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// stimulus
	initial begin
		int words;
		int len;
		logic [5:0] cnt;
		errors            = 0;
		idle_cycles       = 0;
		quiet             = 1'b0;
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_wr_data       = 6'd0;
		data_ch.valid     = 1'b0;
		data_ch.data_byte = 8'h00;
		data_ch.block_end = 1'b0;
		load_parity_count(6'(RESET_PARITY));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				write_count(directed_rows[i].cfg_val);
			else
				send_word(directed_rows[i].data, directed_rows[i].last,
					directed_rows[i].pinned, directed_rows[i].pin_val);
		end

		// random blocks under a handful of counts, extremes included
		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: cnt = 6'd1;
				1: cnt = 6'd32;
				2: cnt = 6'($urandom_range(0, 63));
				3: cnt = 6'($urandom_range(2, 12));
				4: cnt = 6'd16;
				default: cnt = 6'($urandom_range(3, 8));
			endcase
			write_count(cnt);
			quiet = ($urandom_range(0, 3) == 0);
			words = 0;
			while (words < PHASE_WORDS) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
				for (int k = 0; k < len; k++)
					send_word(8'($urandom), (k == len - 1), 1'b0, 8'h00);
				words += len;
				// sender backs off until the parity has all come back
				if ((ph == 2 && words >= PHASE_WORDS / 2 && words - len < PHASE_WORDS / 2) ||
						$urandom_range(0, 15) == 0)
					drain_parity();
			end
		end

		data_ch.valid <= 1'b0;
		while (pending_parity.size() != 0) @(posedge clk);
		repeat (END_GUARD) @(posedge clk);
		if (errors == 0)
			$display("** reed_solomon_parity_encoder_unit: PASSED **");
		else
			$display("** reed_solomon_parity_encoder_unit: FAILED **");
		$finish;
	end

endmodule
